/* design/acp_pkg.sv */
// Shared types and constants for the ASCII clock and contrast command parser.
// No dependencies; imported by every module of the block.
package acp_pkg;

  // Frame window depth (bytes remembered before the present one)
  localparam int unsigned WinDepth = 7;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST  = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_SECOND  = 3'd0;
  localparam logic [2:0] KIND_MINUTE  = 3'd1;
  localparam logic [2:0] KIND_HOUR    = 3'd2;
  localparam logic [2:0] KIND_DAY     = 3'd3;
  localparam logic [2:0] KIND_MONTH   = 3'd4;
  localparam logic [2:0] KIND_YEAR    = 3'd5;
  localparam logic [2:0] KIND_DISPLAY = 3'd6;

  // ASCII characters
  localparam logic [7:0] CH_LOW_S = 8'h73;  // 's'
  localparam logic [7:0] CH_LOW_C = 8'h63;  // 'c'
  localparam logic [7:0] CH_LOW_M = 8'h6D;  // 'm'
  localparam logic [7:0] CH_LOW_H = 8'h68;  // 'h'
  localparam logic [7:0] CH_LOW_D = 8'h64;  // 'd'
  localparam logic [7:0] CH_UP_M  = 8'h4D;  // 'M'
  localparam logic [7:0] CH_UP_Y  = 8'h59;  // 'Y'
  localparam logic [7:0] CH_LOW_O = 8'h6F;  // 'o'
  localparam logic [7:0] CH_LOW_I = 8'h69;  // 'i'
  localparam logic [7:0] CH_CLOSE = 8'h65;  // 'e'
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Display contrast
  localparam logic [7:0] DISP_CONTRAST_CMD = 8'h81;
  localparam logic [7:0] CONTRAST_STEP     = 8'h20;
  localparam logic [7:0] CONTRAST_UP_LIMIT = 8'hDF;
  localparam logic [7:0] CONTRAST_MAX      = 8'hFF;
  localparam logic [7:0] CONTRAST_MIN      = 8'h00;

  // Command passed from the front to the back
  typedef enum logic [1:0] {
    OP_CLOCK,
    OP_UP,
    OP_DOWN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [2:0]  kind;
    logic [13:0] value;
  } acp_cmd_t;

  // Back-end sequencing
  typedef enum logic {
    BK_CMD,
    BK_LEVEL
  } back_state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    return c[3:0];
  endfunction

endpackage

/* design/acp_front.sv */
// Front end: byte window, fill count and command recognition.
// Depends on acp_pkg; pushes recognized commands into the command queue.
module acp_front
  import acp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  input  logic        clock_set_enable,
  input  logic        contrast_enable,
  output logic        push,
  output acp_cmd_t    cmd
);

  logic [7:0] win_r [WinDepth];
  logic [7:0] win_nxt [WinDepth];
  logic [2:0] fill_r;
  logic [2:0] fill_nxt;
  logic [7:0] p [1:WinDepth];
  logic [2:0] fill_eff;

  // Clear the window at a frame start before using it
  always_comb begin
    for (int k = 1; k <= WinDepth; k++) begin
      p[k] = frame_start ? 8'h00 : win_r[k-1];
    end
    fill_eff = frame_start ? 3'd0 : fill_r;
  end

  // Match the commands that close on this byte
  logic        short_hit;
  logic        year_hit;
  logic        con_hit;
  logic        short_kind_ok;
  logic [2:0]  short_kind;
  logic [13:0] short_val;
  logic [13:0] year_val;

  always_comb begin
    short_kind_ok = 1'b1;
    short_kind    = KIND_SECOND;
    unique case (p[3])
      CH_LOW_S: short_kind = KIND_SECOND;
      CH_LOW_M: short_kind = KIND_MINUTE;
      CH_LOW_H: short_kind = KIND_HOUR;
      CH_LOW_D: short_kind = KIND_DAY;
      CH_UP_M:  short_kind = KIND_MONTH;
      default:  short_kind_ok = 1'b0;
    endcase
  end

  assign short_val = 14'(digit_val(p[2])) * 14'd10 + 14'(digit_val(p[1]));
  assign year_val  = 14'(digit_val(p[4])) * 14'd1000 + 14'(digit_val(p[3])) * 14'd100
                   + 14'(digit_val(p[2])) * 14'd10 + 14'(digit_val(p[1]));

  assign short_hit = (fill_eff >= 3'd5) && (p[5] == CH_LOW_S) && (p[4] == CH_LOW_C)
                   && is_digit(p[2]) && is_digit(p[1]) && short_kind_ok;
  assign year_hit  = (fill_eff == 3'd7) && (p[7] == CH_LOW_S) && (p[6] == CH_LOW_C)
                   && (p[5] == CH_UP_Y) && is_digit(p[4]) && is_digit(p[3])
                   && is_digit(p[2]) && is_digit(p[1]);
  assign con_hit   = (fill_eff >= 3'd3) && (p[3] == CH_LOW_S) && (p[2] == CH_LOW_O)
                   && ((p[1] == CH_LOW_I) || (p[1] == CH_LOW_D));

  // Pick the command; clock commands win over contrast
  always_comb begin
    push      = 1'b0;
    cmd.op    = OP_CLOCK;
    cmd.kind  = short_kind;
    cmd.value = short_val;
    priority if (rx_byte == CH_CLOSE && clock_set_enable && short_hit) begin
      push = accept;
    end else if (rx_byte == CH_CLOSE && clock_set_enable && year_hit) begin
      push      = accept;
      cmd.kind  = KIND_YEAR;
      cmd.value = year_val;
    end else if (rx_byte == CH_CLOSE && contrast_enable && con_hit) begin
      push      = accept;
      cmd.op    = (p[1] == CH_LOW_I) ? OP_UP : OP_DOWN;
      cmd.kind  = KIND_DISPLAY;
      cmd.value = 14'(DISP_CONTRAST_CMD);
    end else begin
      push = 1'b0;
    end
  end

  // Shift the new byte into the window
  always_comb begin
    win_nxt[0] = rx_byte;
    for (int k = 1; k < WinDepth; k++) begin
      win_nxt[k] = p[k];
    end
    fill_nxt = (fill_eff == 3'd7) ? 3'd7 : fill_eff + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 3'd0;
      for (int k = 0; k < WinDepth; k++) begin
        win_r[k] <= 8'h00;
      end
    end else if (accept) begin
      fill_r <= fill_nxt;
      for (int k = 0; k < WinDepth; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

endmodule

/* design/acp_cmd_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on acp_pkg for the command word type.
module acp_cmd_fifo
  import acp_pkg::*;
#(
  parameter int unsigned DEPTH = 2
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  acp_cmd_t push_cmd,
  input  logic     pop,
  output logic     full,
  output logic     nonempty,
  output acp_cmd_t head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  acp_cmd_t       mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full     = (count_r == CntW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];

  // Store the word at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* design/acp_back.sv */
// Back end: carries out queued commands, keeps the contrast level and
// drives the output register. Depends on acp_pkg.
module acp_back
  import acp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  acp_cmd_t    cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [13:0] out_result_value,
  output logic        out_last_of_run
);

  back_state_t state_r, state_nxt;
  logic [7:0]  level_r, level_nxt;
  logic        valid_r, valid_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [13:0] value_r, value_nxt;
  logic        last_r, last_nxt;
  logic        emit;
  logic        load;

  assign load = !valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CMD: begin
        if (cmd_valid && load && cmd.op != OP_CLOCK) begin
          state_nxt = BK_LEVEL;
        end
      end
      BK_LEVEL: begin
        if (load) begin
          state_nxt = BK_CMD;
        end
      end
      default: state_nxt = BK_CMD;
    endcase
  end

  // Outputs, word payload and contrast update
  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    level_nxt = level_r;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    unique case (state_r)
      BK_CMD: begin
        if (cmd_valid && load) begin
          emit      = 1'b1;
          kind_nxt  = cmd.kind;
          value_nxt = cmd.value;
          unique case (cmd.op)
            OP_CLOCK: begin
              pop      = 1'b1;
              last_nxt = 1'b1;
            end
            OP_UP: begin
              last_nxt  = 1'b0;
              level_nxt = (level_r < CONTRAST_UP_LIMIT) ? level_r + CONTRAST_STEP
                                                        : CONTRAST_MAX;
            end
            OP_DOWN: begin
              last_nxt  = 1'b0;
              level_nxt = (level_r >= CONTRAST_STEP) ? level_r - CONTRAST_STEP
                                                     : CONTRAST_MIN;
            end
            default: begin
              pop = 1'b1;
              emit = 1'b0;
            end
          endcase
        end
      end
      BK_LEVEL: begin
        if (load) begin
          emit      = 1'b1;
          pop       = 1'b1;
          kind_nxt  = KIND_DISPLAY;
          value_nxt = 14'(level_r);
          last_nxt  = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    valid_nxt = emit ? 1'b1 : (load ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CMD;
      level_r <= CONTRAST_MAX;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_result_kind  = kind_r;
  assign out_result_value = value_r;
  assign out_last_of_run  = last_r;

endmodule

/* design/ascii_clock_and_contrast_command_parser.sv */
// ASCII clock and contrast command parser, top level.
// A recognized command passes through the command queue and then the back end's output
// register before out_valid rises. Throughput: one byte per cycle while the command
// queue has room; a clock command yields one result word, a contrast command two.
// Reset (synchronous, rst_n low): empty window, empty queue, contrast 0xFF,
// both command groups enabled. Depends on acp_pkg, acp_front, acp_cmd_fifo, acp_back.
module ascii_clock_and_contrast_command_parser
  import acp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_result_kind,
  output logic [13:0]           out_result_value,
  output logic                  out_last_of_run
);

  logic     clock_set_enable_r;
  logic     contrast_enable_r;
  logic     accept;
  logic     push;
  logic     pop;
  logic     full;
  logic     nonempty;
  acp_cmd_t push_cmd;
  acp_cmd_t head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_set_enable_r <= 1'b1;
      contrast_enable_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLOCK_SET: clock_set_enable_r <= cfg_wdata[0];
        CFG_CONTRAST:  contrast_enable_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  acp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .rx_byte          (in_rx_byte),
    .frame_start      (in_frame_start),
    .clock_set_enable (clock_set_enable_r),
    .contrast_enable  (contrast_enable_r),
    .push             (push),
    .cmd              (push_cmd)
  );

  acp_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .head     (head)
  );

  acp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (nonempty),
    .cmd              (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

/* tb/tb_ascii_clock_and_contrast_command_parser.sv */
// Testbench for ascii_clock_and_contrast_command_parser: directed and random command
// streams under random idling and stalls, checked word by word by an in-bench predictor.
// Depends on acp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_ascii_clock_and_contrast_command_parser;
  import acp_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [13:0] value;
    logic        last;
  } result_word_t;

  // Predictor state plus the queue of words the block still owes
  class cmd_scoreboard;
    logic [7:0]   recent[WinDepth];
    int unsigned  fill;
    logic [7:0]   level;
    bit           clock_en;
    bit           contrast_en;
    result_word_t expected_words[$];
    int           errors;

    function new();
      foreach (recent[i]) recent[i] = '0;
      fill = 0;
      level = CONTRAST_MAX;
      clock_en = 1'b1;
      contrast_en = 1'b1;
      errors = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic v);
      if (idx == CFG_CLOCK_SET) begin
        clock_en = v;
      end else begin
        contrast_en = v;
      end
    endfunction

    function bit numeral(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function int unsigned num_val(logic [7:0] c);
      return int'(c) - int'(CH_ZERO);
    endfunction

    function void add_word(logic [2:0] kind, int unsigned value, logic last);
      result_word_t w;
      w.kind = kind;
      w.value = value[13:0];
      w.last = last;
      expected_words.push_back(w);
    endfunction

    // Two-digit field set, then four-digit year
    function int decode_clock();
      logic [2:0]  kind;
      bit          known;
      int unsigned v;
      if (fill >= 5 && recent[4] == CH_LOW_S && recent[3] == CH_LOW_C &&
          numeral(recent[1]) && numeral(recent[0])) begin
        known = 1'b1;
        case (recent[2])
          CH_LOW_S: kind = KIND_SECOND;
          CH_LOW_M: kind = KIND_MINUTE;
          CH_LOW_H: kind = KIND_HOUR;
          CH_LOW_D: kind = KIND_DAY;
          CH_UP_M:  kind = KIND_MONTH;
          default:  known = 1'b0;
        endcase
        if (known) begin
          add_word(kind, num_val(recent[1]) * 10 + num_val(recent[0]), 1'b1);
          return 1;
        end
      end
      if (fill >= 7 && recent[6] == CH_LOW_S && recent[5] == CH_LOW_C &&
          recent[4] == CH_UP_Y && numeral(recent[3]) && numeral(recent[2]) &&
          numeral(recent[1]) && numeral(recent[0])) begin
        v = num_val(recent[3]) * 1000 + num_val(recent[2]) * 100 +
            num_val(recent[1]) * 10 + num_val(recent[0]);
        add_word(KIND_YEAR, v, 1'b1);
        return 1;
      end
      return 0;
    endfunction

    // Contrast up or down, saturating at both ends
    function int step_contrast();
      if (fill < 3 || recent[2] != CH_LOW_S || recent[1] != CH_LOW_O) return 0;
      if (recent[0] == CH_LOW_I) begin
        level = (level < CONTRAST_UP_LIMIT) ? level + CONTRAST_STEP : CONTRAST_MAX;
      end else if (recent[0] == CH_LOW_D) begin
        level = (level >= CONTRAST_STEP) ? level - CONTRAST_STEP : CONTRAST_MIN;
      end else begin
        return 0;
      end
      add_word(KIND_DISPLAY, DISP_CONTRAST_CMD, 1'b0);
      add_word(KIND_DISPLAY, level, 1'b1);
      return 2;
    endfunction

    // Note one accepted input word
    function void note_byte(logic [7:0] b, logic fs);
      int n;
      n = 0;
      if (fs) begin
        foreach (recent[i]) recent[i] = '0;
        fill = 0;
      end
      if (b == CH_CLOSE) begin
        if (clock_en) n = decode_clock();
        if (n == 0 && contrast_en) n = step_contrast();
      end
      for (int k = WinDepth - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = b;
      if (fill < WinDepth) fill++;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Check one accepted result word against the oldest expectation
    task check_result(logic [2:0] kind, logic [13:0] value, logic last);
      result_word_t w;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d value %0d", kind, value));
        return;
      end
      w = expected_words.pop_front();
      if (kind !== w.kind)
        report_mismatch($sformatf("kind %0d, wanted %0d", kind, w.kind));
      if (value !== w.value)
        report_mismatch($sformatf("value %0d, wanted %0d", value, w.value));
      if (last !== w.last)
        report_mismatch($sformatf("last_of_run %0b, wanted %0b", last, w.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_rx_byte;
  logic                  in_frame_start;
  logic                  out_valid;
  logic                  out_stall;
  logic [2:0]            out_result_kind;
  logic [13:0]           out_result_value;
  logic                  out_last_of_run;

  cmd_scoreboard sb = new();
  int            gap_mode = 0;
  int            items_sent = 0;
  bit            hold_off_req = 1'b0;
  logic [7:0]    cmd_q[$];
  logic          fs_q[$];
  logic [7:0]    field_chars[5] = '{CH_LOW_S, CH_LOW_M, CH_LOW_H, CH_LOW_D, CH_UP_M};

  ascii_clock_and_contrast_command_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value),
    .out_last_of_run  (out_last_of_run)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, a few long ones; mode 0 means no idling
  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] digit_char();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic push_byte(logic [7:0] b, logic fs);
    int gap;
    gap = pick_gap(gap_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, fs);
    items_sent++;
  endtask

  task automatic push_text(string s, logic fs_first);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], fs_first && (i == 0));
  endtask

  // Write both enables once the block has gone quiet
  task automatic write_cfg(logic clock_set, logic contrast);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CLOCK_SET;
    cfg_wdata <= clock_set;
    @(posedge clk);
    sb.set_config(CFG_CLOCK_SET, clock_set);
    cfg_index <= CFG_CONTRAST;
    cfg_wdata <= contrast;
    @(posedge clk);
    sb.set_config(CFG_CONTRAST, contrast);
    cfg_we <= 1'b0;
  endtask

  // Build one well-formed command with random content, or noise
  task automatic compose_command();
    int r;
    cmd_q.delete();
    fs_q.delete();
    r = $urandom_range(0, 99);
    if (r < 32) begin
      cmd_q = '{CH_LOW_S, CH_LOW_C, field_chars[$urandom_range(0, 4)],
                digit_char(), digit_char(), CH_CLOSE};
    end else if (r < 47) begin
      cmd_q = '{CH_LOW_S, CH_LOW_C, CH_UP_Y, digit_char(), digit_char(),
                digit_char(), digit_char(), CH_CLOSE};
    end else if (r < 77) begin
      cmd_q = '{CH_LOW_S, CH_LOW_O, ($urandom_range(0, 1) ? CH_LOW_I : CH_LOW_D), CH_CLOSE};
    end else begin
      repeat ($urandom_range(1, 5))
        cmd_q.push_back(($urandom_range(0, 4) == 0) ? CH_CLOSE : 8'($urandom_range(0, 255)));
    end
    foreach (cmd_q[k]) fs_q.push_back((r >= 77) && ($urandom_range(0, 19) == 0));
    if (r < 77) begin
      fs_q[0] = ($urandom_range(0, 99) < 35);
      // split by a frame start, or break one byte
      if ($urandom_range(0, 99) < 8) fs_q[$urandom_range(1, cmd_q.size() - 1)] = 1'b1;
      if ($urandom_range(0, 99) < 8)
        cmd_q[$urandom_range(0, cmd_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic run_random(int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 11) == 0) gap_mode = $urandom_range(0, 3);
      compose_command();
      foreach (cmd_q[k]) push_byte(cmd_q[k], fs_q[k]);
    end
  endtask

  // Check every result word the receiver takes
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_result_kind, out_result_value, out_last_of_run);
  end

  // Receiver: random stalls, stall-free stretches, one long hold-off on request
  initial begin
    int n;
    int m;
    int mode;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      n = (mode == 0) ? 0 : pick_gap(1);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      m = (mode == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      repeat (m) @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_CLOCK_SET;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_rx_byte     <= '0;
    in_frame_start <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_cfg(1'b1, 1'b1);

    // Directed: year at its top, contrast saturating high, month at zero, byte extremes
    push_text("scY9999e", 1'b1);
    push_text("soie", 1'b1);
    push_text("sode", 1'b0);
    push_text("scM00e", 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);

    // Random phases across enable settings; fill the block during the first
    gap_mode = 1;
    hold_off_req = 1'b1;
    run_random(600);
    write_cfg(1'b0, 1'b1);
    run_random(300);
    write_cfg(1'b1, 1'b0);
    run_random(300);
    write_cfg(1'b0, 1'b0);
    run_random(150);
    write_cfg(1'b1, 1'b1);
    run_random(600);

    // Drain, then allow for stray words
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
